// File: sv/scht_pkg.sv
// Package: types, constants and codes shared by the spatial cell hash table.
package scht_pkg;

  // Default sizes for the top-level parameters; TABLE_SLOTS is a power of two
  localparam int TABLE_SLOTS_DEF  = 1024;
  localparam int MAX_PER_CELL_DEF = 8;
  localparam int INDEX_BITS_DEF   = 16;
  localparam int GEN_BITS_DEF     = 8;

  // Reset value of the live-cell limit register
  localparam logic [10:0] CELL_LIMIT_RST = 11'd716;

  // Hash constants: per-axis primes and the finalizer multiplier
  localparam logic [31:0] PRIME_X  = 32'd73856093;
  localparam logic [31:0] PRIME_Y  = 32'd19349663;
  localparam logic [31:0] PRIME_Z  = 32'd83492791;
  localparam logic [63:0] MIX_MULT = 64'hff51afd7ed558ccd;
  localparam int          MIX_SHIFT = 33;

  typedef enum logic [1:0] {
    CMD_BUILD  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_BUILD_STARTED = 3'd0,
    ST_APPENDED      = 3'd1,
    ST_APPENDED_NEW  = 3'd2,
    ST_TABLE_FULL    = 3'd3,
    ST_CELL_FULL     = 3'd4,
    ST_HIT           = 3'd5,
    ST_MISS          = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic [15:0]        item_index;
    logic [15:0]        query_tag;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] found_index;
    logic [15:0] echo_tag;
    logic        last;
    logic [10:0] live_cells;
  } out_item_t;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MX,
    OP_MY,
    OP_MZ,
    OP_MIX1,
    OP_PLL,
    OP_PLH,
    OP_PHL,
    OP_MIX2,
    OP_HOME,
    OP_PROBE_RD,
    OP_PROBE_ADV,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_BUILD,
    OP_GEN_ONE,
    OP_APPEND,
    OP_CLAIM,
    OP_ITEM_RD
  } dp_op_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_MX,
    S_MY,
    S_MZ,
    S_MIX1,
    S_PLL,
    S_PLH,
    S_PHL,
    S_MIX2,
    S_HOME,
    S_PRD,
    S_PCHK,
    S_BUILD,
    S_BCHK,
    S_WRAP_CLR,
    S_GEN1,
    S_EMIT,
    S_QRD,
    S_QEMIT
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    logic    emit;
    status_t emit_status;
    logic    emit_last;
    logic    emit_tag;
  } ctrl_cmd_t;

  typedef struct packed {
    logic gen_zero;
    logic live;
    logic match;
    logic fill_full;
    logic fill_zero;
    logic probe_full;
    logic limit_hit;
    logic clr_done;
    logic qi_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/scht_ctrl.sv
// Controller: sequences hashing, probing, updates and result emission.
module scht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  output logic               in_ready,
  input  scht_pkg::dp_stat_t stat,
  output scht_pkg::ctrl_cmd_t cmd
);
  import scht_pkg::*;

  state_t   state_r, state_nxt;
  command_t cmd_r, cmd_nxt;
  status_t  code_r, code_nxt;

  // Hold state, latched command and pending result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cmd_r   <= CMD_NONE;
      code_r  <= ST_MISS;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
      code_r  <= code_nxt;
    end
  end

  // Decide next state and datapath command
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    code_nxt        = code_r;
    in_ready        = 1'b0;
    cmd.op          = OP_NONE;
    cmd.emit        = 1'b0;
    cmd.emit_status = code_r;
    cmd.emit_last   = 1'b1;
    cmd.emit_tag    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR_STEP;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op  = OP_LOAD;
          cmd_nxt = command_t'(in_cmd);
          case (command_t'(in_cmd))
            CMD_BUILD: state_nxt = S_BUILD;
            CMD_INSERT: begin
              if (stat.gen_zero) begin
                code_nxt  = ST_TABLE_FULL;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_MX;
              end
            end
            CMD_QUERY: begin
              if (stat.gen_zero) begin
                code_nxt  = ST_MISS;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_MX;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MX: begin
        cmd.op = OP_MX;
        state_nxt = S_MY;
      end
      S_MY: begin
        cmd.op = OP_MY;
        state_nxt = S_MZ;
      end
      S_MZ: begin
        cmd.op = OP_MZ;
        state_nxt = S_MIX1;
      end
      S_MIX1: begin
        cmd.op = OP_MIX1;
        state_nxt = S_PLL;
      end
      S_PLL: begin
        cmd.op = OP_PLL;
        state_nxt = S_PLH;
      end
      S_PLH: begin
        cmd.op = OP_PLH;
        state_nxt = S_PHL;
      end
      S_PHL: begin
        cmd.op = OP_PHL;
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        cmd.op = OP_MIX2;
        state_nxt = S_HOME;
      end
      S_HOME: begin
        cmd.op = OP_HOME;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        cmd.op = OP_PROBE_RD;
        state_nxt = S_PCHK;
      end
      // Resolve the probed slot: match, free slot or keep walking
      S_PCHK: begin
        if (stat.live && stat.match) begin
          if (cmd_r == CMD_INSERT) begin
            if (stat.fill_full) begin
              code_nxt = ST_CELL_FULL;
            end else begin
              cmd.op   = OP_APPEND;
              code_nxt = ST_APPENDED;
            end
            state_nxt = S_EMIT;
          end else if (stat.fill_zero) begin
            code_nxt  = ST_MISS;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_QRD;
          end
        end else if (!stat.live) begin
          if (cmd_r == CMD_INSERT) begin
            if (stat.limit_hit) begin
              code_nxt = ST_TABLE_FULL;
            end else begin
              cmd.op   = OP_CLAIM;
              code_nxt = ST_APPENDED_NEW;
            end
          end else begin
            code_nxt = ST_MISS;
          end
          state_nxt = S_EMIT;
        end else if (stat.probe_full) begin
          code_nxt  = (cmd_r == CMD_INSERT) ? ST_TABLE_FULL : ST_MISS;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_PROBE_ADV;
          state_nxt = S_PRD;
        end
      end
      S_BUILD: begin
        cmd.op    = OP_BUILD;
        code_nxt  = ST_BUILD_STARTED;
        state_nxt = S_BCHK;
      end
      S_BCHK: begin
        if (stat.gen_zero) begin
          cmd.op    = OP_CLR_INIT;
          state_nxt = S_WRAP_CLR;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_WRAP_CLR: begin
        cmd.op = OP_CLR_STEP;
        if (stat.clr_done) state_nxt = S_GEN1;
      end
      S_GEN1: begin
        cmd.op    = OP_GEN_ONE;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_tag = (cmd_r == CMD_QUERY);
          state_nxt    = S_IDLE;
        end
      end
      S_QRD: begin
        cmd.op    = OP_ITEM_RD;
        state_nxt = S_QEMIT;
      end
      // Emit one stored index; advance or finish
      S_QEMIT: begin
        cmd.emit_status = ST_HIT;
        cmd.emit_last   = stat.qi_last;
        cmd.emit_tag    = 1'b1;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.qi_last ? S_IDLE : S_QRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: sv/scht_dp.sv
// Datapath: hash unit, slot and item memories, counters and output register.
module scht_dp #(
  parameter int TABLE_SLOTS  = scht_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_PER_CELL = scht_pkg::MAX_PER_CELL_DEF,
  parameter int INDEX_BITS   = scht_pkg::INDEX_BITS_DEF,
  parameter int GEN_BITS     = scht_pkg::GEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scht_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  logic [10:0]          cfg_data,
  input  scht_pkg::ctrl_cmd_t  cmd,
  output scht_pkg::dp_stat_t   stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scht_pkg::out_item_t  out_data
);
  import scht_pkg::*;

  localparam int SB        = $clog2(TABLE_SLOTS);
  localparam int FILL_BITS = $clog2(MAX_PER_CELL + 1);
  localparam int ACT_BITS  = $clog2(TABLE_SLOTS + 1);
  localparam int IA_BITS   = $clog2(TABLE_SLOTS * MAX_PER_CELL);
  localparam int SW        = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam int CW        = (ACT_BITS > 11) ? ACT_BITS : 11;
  localparam int ITEMS     = TABLE_SLOTS * MAX_PER_CELL;

  typedef struct packed {
    logic [GEN_BITS-1:0]  gen;
    logic [FILL_BITS-1:0] fill;
    logic [31:0]          kx;
    logic [31:0]          ky;
    logic [31:0]          kz;
  } slot_word_t;

  slot_word_t slot_mem [TABLE_SLOTS];
  logic [SW-1:0] item_mem [ITEMS];

  in_item_t              in_r;
  logic [63:0]           h_r;
  logic [63:0]           p_r;
  logic [SB-1:0]         slot_r;
  logic [SB-1:0]         n_r;
  logic [SB-1:0]         clr_r;
  logic [GEN_BITS-1:0]   gen_r;
  logic [ACT_BITS-1:0]   active_r;
  logic [10:0]           limit_r;
  logic [FILL_BITS-1:0]  qi_r;
  slot_word_t            rd_r;
  logic [SW-1:0]         item_rd_r;
  out_item_t             out_r;
  logic                  out_valid_r;

  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod;
  logic                  slot_we;
  logic [SB-1:0]         slot_wa;
  slot_word_t            slot_wd;
  logic                  item_we;
  logic [IA_BITS-1:0]    item_wa;
  logic [IA_BITS-1:0]    slot_base;
  logic                  out_free;

  // Select multiplier operands for the hash step
  always_comb begin
    mul_a = in_r.cell_x;
    mul_b = PRIME_X;
    case (cmd.op)
      OP_MY: begin
        mul_a = in_r.cell_y;
        mul_b = PRIME_Y;
      end
      OP_MZ: begin
        mul_a = in_r.cell_z;
        mul_b = PRIME_Z;
      end
      OP_PLL: begin
        mul_a = h_r[31:0];
        mul_b = MIX_MULT[31:0];
      end
      OP_PLH: begin
        mul_a = h_r[31:0];
        mul_b = MIX_MULT[63:32];
      end
      OP_PHL: begin
        mul_a = h_r[63:32];
        mul_b = MIX_MULT[31:0];
      end
      default: begin
        mul_a = in_r.cell_x;
        mul_b = PRIME_X;
      end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  // Form memory writes for clear, claim and append
  always_comb begin
    slot_base = IA_BITS'(slot_r) * IA_BITS'(MAX_PER_CELL);
    slot_we   = 1'b0;
    slot_wa   = slot_r;
    slot_wd   = rd_r;
    item_we   = 1'b0;
    item_wa   = slot_base;
    case (cmd.op)
      OP_CLR_STEP: begin
        slot_we = 1'b1;
        slot_wa = clr_r;
        slot_wd = '0;
      end
      OP_CLAIM: begin
        slot_we = 1'b1;
        slot_wd = '{gen: gen_r, fill: FILL_BITS'(1),
                    kx: in_r.cell_x, ky: in_r.cell_y, kz: in_r.cell_z};
        item_we = 1'b1;
      end
      OP_APPEND: begin
        slot_we      = 1'b1;
        slot_wd.fill = rd_r.fill + FILL_BITS'(1);
        item_we      = 1'b1;
        item_wa      = slot_base + IA_BITS'(rd_r.fill);
      end
      default: slot_we = 1'b0;
    endcase
  end

  // Write and read the memories
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd.op == OP_PROBE_RD) rd_r <= slot_mem[slot_r];
    if (item_we) item_mem[item_wa] <= in_r.item_index[SW-1:0];
    if (cmd.op == OP_ITEM_RD) item_rd_r <= item_mem[slot_base + IA_BITS'(qi_r)];
  end

  // Hold item payload, hash words and probe position
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        in_r <= in_data;
        qi_r <= '0;
      end
      OP_MX:   h_r <= prod;
      OP_MY:   h_r <= h_r ^ prod;
      OP_MZ:   h_r <= h_r ^ prod;
      OP_MIX1: h_r <= h_r ^ (h_r >> MIX_SHIFT);
      OP_PLL:  p_r <= prod;
      OP_PLH:  p_r[63:32] <= p_r[63:32] + prod[31:0];
      OP_PHL:  p_r[63:32] <= p_r[63:32] + prod[31:0];
      OP_MIX2: p_r <= p_r ^ (p_r >> MIX_SHIFT);
      // Home slot is the low hash bits of a power-of-two table
      OP_HOME: begin
        slot_r <= p_r[SB-1:0];
        n_r    <= '0;
      end
      OP_PROBE_ADV: begin
        slot_r <= (slot_r == SB'(TABLE_SLOTS - 1)) ? '0 : slot_r + SB'(1);
        n_r    <= n_r + SB'(1);
      end
      OP_ITEM_RD: qi_r <= qi_r + FILL_BITS'(1);
      default: qi_r <= qi_r;
    endcase
  end

  // Advance generation, live count, clear pointer and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r    <= '0;
      active_r <= '0;
      clr_r    <= '0;
      limit_r  <= CELL_LIMIT_RST;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      case (cmd.op)
        OP_BUILD: begin
          gen_r    <= gen_r + GEN_BITS'(1);
          active_r <= '0;
        end
        OP_GEN_ONE:  gen_r <= GEN_BITS'(1);
        OP_CLR_INIT: clr_r <= '0;
        OP_CLR_STEP: clr_r <= clr_r + SB'(1);
        OP_CLAIM:    active_r <= active_r + ACT_BITS'(1);
        default:     gen_r <= gen_r;
      endcase
    end
  end

  // Load the output register; drop valid once taken
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      out_r.status      <= cmd.emit_status;
      out_r.found_index <= (cmd.emit_status == ST_HIT) ? 16'(item_rd_r) : 16'd0;
      out_r.echo_tag    <= cmd.emit_tag ? in_r.query_tag : 16'd0;
      out_r.last        <= cmd.emit_last;
      out_r.live_cells  <= 11'(active_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Report status to the controller
  always_comb begin
    stat.gen_zero   = (gen_r == '0);
    stat.live       = (rd_r.gen == gen_r);
    stat.match      = (rd_r.kx == in_r.cell_x) && (rd_r.ky == in_r.cell_y) &&
                      (rd_r.kz == in_r.cell_z);
    stat.fill_full  = (rd_r.fill >= FILL_BITS'(MAX_PER_CELL));
    stat.fill_zero  = (rd_r.fill == '0);
    stat.probe_full = (n_r == SB'(TABLE_SLOTS - 1));
    stat.limit_hit  = (CW'(active_r) >= CW'(limit_r)) ||
                      (active_r >= ACT_BITS'(TABLE_SLOTS));
    stat.clr_done   = (clr_r == SB'(TABLE_SLOTS - 1));
    stat.qi_last    = (qi_r >= rd_r.fill);
    stat.out_free   = out_free;
  end

endmodule

// File: sv/spatial_cell_hash_table.sv
// Top level: spatial cell hash table with insert, query and build commands.
// Use: send items on in_valid/in_ready with in_data (command, cell_x/y/z,
// item_index, query_tag); results leave on out_valid/out_ready as out_data.
// cfg_valid/cfg_data writes the live-cell limit; cfg_ready is always high.
// One item is worked at a time; in_ready is high only while the controller
// waits for work, also while a result still sits in the output register.
// TABLE_SLOTS is a power of two; the home slot is the low hash bits.
// A build steps the generation, adding a pass of tag clearing and a restart
// when the generation wraps. Insert and a query miss take an accept step, nine
// hash steps through one shared 32x32 multiplier, a registered slot read and a
// check per probed slot, and a step to load the result. A query hit loads its
// results one per stored index, read one at a time from the item memory, in
// place of that last step. Unknown commands produce no result.
// Reset starts a clearing pass over the slot memory; no item is accepted
// until it ends, configuration writes are still taken.
// When the receiver stalls, the result holds in the output register and the
// controller waits before writing the next one.
module spatial_cell_hash_table #(
  parameter int TABLE_SLOTS  = scht_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_PER_CELL = scht_pkg::MAX_PER_CELL_DEF,
  parameter int INDEX_BITS   = scht_pkg::INDEX_BITS_DEF,
  parameter int GEN_BITS     = scht_pkg::GEN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scht_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scht_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [10:0]         cfg_data
);
  import scht_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  scht_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_cmd  (in_data.command),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  scht_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_PER_CELL(MAX_PER_CELL),
    .INDEX_BITS  (INDEX_BITS),
    .GEN_BITS    (GEN_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Emit only into a free output register
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> stat.out_free)
    else $error("result emitted while output register busy");

  // Real commands make the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command != CMD_NONE) |=> !in_ready)
    else $error("accepted a new item while one is in progress");

  // Clearing pass blocks input right after reset
  assert property (@(posedge clk) (rst_n && !$past(rst_n)) |-> !in_ready)
    else $error("input accepted during reset clearing pass");

  // Only hit results can be followed by more results
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_HIT) |-> out_data.last)
    else $error("non-hit result without last");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the spatial cell hash table: directed and random command streams.
module testbench;
  import scht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 1024;
  localparam int PER_CELL  = 8;
  localparam int GEN_W     = 2;
  localparam int SETTLE    = 100;
  localparam int STALL_MAX = 20000;
  localparam int POOL_N    = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  // Narrow generation so a wrap takes only a few builds
  spatial_cell_hash_table #(
    .GEN_BITS(GEN_W)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table
  logic [31:0]      key_x [SLOTS];
  logic [31:0]      key_y [SLOTS];
  logic [31:0]      key_z [SLOTS];
  logic [GEN_W-1:0] slot_gen [SLOTS];
  int               slot_fill [SLOTS];
  logic [15:0]      slot_list [SLOTS][PER_CELL];
  logic [GEN_W-1:0] build_gen = '0;
  int               live_count = 0;
  int               live_limit = int'(CELL_LIMIT_RST);

  out_item_t   pending_results[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  bit          jitter_on = 1'b1;

  // Coordinate pool for well-formed random sequences
  logic [31:0] pool_x [POOL_N];
  logic [31:0] pool_y [POOL_N];
  logic [31:0] pool_z [POOL_N];

  function automatic logic [9:0] home_of(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [63:0] h;
    h = {32'b0, x} * {32'b0, PRIME_X};
    h ^= {32'b0, y} * {32'b0, PRIME_Y};
    h ^= {32'b0, z} * {32'b0, PRIME_Z};
    h ^= h >> MIX_SHIFT;
    h = h * MIX_MULT;
    h ^= h >> MIX_SHIFT;
    return h[9:0];
  endfunction

  // Walk from the home slot; slot is the match, first free slot, or SLOTS
  function automatic bit find_cell(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   output int slot);
    int s;
    s = int'(home_of(x, y, z));
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_gen[s] != build_gen) begin
        slot = s;
        return 1'b0;
      end
      if (key_x[s] == x && key_y[s] == y && key_z[s] == z) begin
        slot = s;
        return 1'b1;
      end
      s = (s + 1) % SLOTS;
    end
    slot = SLOTS;
    return 1'b0;
  endfunction

  // Append one expected result
  task automatic queue_result(input out_item_t r);
    pending_results = {pending_results, r};
  endtask

  // Compute the results one accepted item causes
  task automatic predict_results(input in_item_t it);
    out_item_t r;
    int        s;
    bit        hit;
    r = '0;
    r.last = 1'b1;
    case (it.command)
      CMD_BUILD: begin
        build_gen = build_gen + GEN_W'(1);
        if (build_gen == '0) begin
          foreach (slot_gen[i]) slot_gen[i] = '0;
          build_gen = GEN_W'(1);
        end
        live_count = 0;
        r.status = ST_BUILD_STARTED;
        r.live_cells = 11'(live_count);
        queue_result(r);
      end
      CMD_INSERT: begin
        if (build_gen == '0) begin
          r.status = ST_TABLE_FULL;
        end else begin
          hit = find_cell(it.cell_x, it.cell_y, it.cell_z, s);
          if (hit) begin
            if (slot_fill[s] >= PER_CELL) begin
              r.status = ST_CELL_FULL;
            end else begin
              slot_list[s][slot_fill[s]] = it.item_index;
              slot_fill[s]++;
              r.status = ST_APPENDED;
            end
          end else if (s >= SLOTS || live_count >= live_limit || live_count >= SLOTS) begin
            r.status = ST_TABLE_FULL;
          end else begin
            key_x[s] = it.cell_x;
            key_y[s] = it.cell_y;
            key_z[s] = it.cell_z;
            slot_gen[s] = build_gen;
            slot_list[s][0] = it.item_index;
            slot_fill[s] = 1;
            live_count++;
            r.status = ST_APPENDED_NEW;
          end
        end
        r.live_cells = 11'(live_count);
        queue_result(r);
      end
      CMD_QUERY: begin
        r.echo_tag = it.query_tag;
        r.live_cells = 11'(live_count);
        hit = (build_gen != '0) && find_cell(it.cell_x, it.cell_y, it.cell_z, s);
        if (!hit || slot_fill[s] == 0) begin
          r.status = ST_MISS;
          queue_result(r);
        end else begin
          for (int i = 0; i < slot_fill[s]; i++) begin
            r.status = ST_HIT;
            r.found_index = slot_list[s][i];
            r.last = (i + 1 == slot_fill[s]);
            queue_result(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Present one item; returns at the falling edge after acceptance, valid still high
  task automatic send_item(input in_item_t it);
    int gap;
    gap = (jitter_on && $urandom_range(99) < 35) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_results(it);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(command_t cmd, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [15:0] idx,
                                         logic [15:0] tag);
    in_item_t it;
    it.command = cmd;
    it.cell_x = x;
    it.cell_y = y;
    it.cell_z = z;
    it.item_index = idx;
    it.query_tag = tag;
    return it;
  endfunction

  // Drop valid and hold until every expected result is back, then settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_limit(input logic [10:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    live_limit = int'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stall
  always @(negedge clk) begin
    out_ready <= jitter_on ? ($urandom_range(99) >= 35) : 1'b1;
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d index=%h tag=%h last=%b live=%0d",
                 $time, out_data.status, out_data.found_index, out_data.echo_tag,
                 out_data.last, out_data.live_cells);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.found_index !== want.found_index) begin
          $display("%0t: found_index expected %h actual %h", $time, want.found_index,
                   out_data.found_index);
          errors++;
        end
        if (out_data.echo_tag !== want.echo_tag) begin
          $display("%0t: echo_tag expected %h actual %h", $time, want.echo_tag,
                   out_data.echo_tag);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_data.last);
          errors++;
        end
        if (out_data.live_cells !== want.live_cells) begin
          $display("%0t: live_cells expected %0d actual %0d", $time, want.live_cells,
                   out_data.live_cells);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("%0t: no progress, %0d results outstanding", $time, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // No build open yet: insert refused, query misses, unknown command dropped
  task automatic test_before_build();
    send_item(make_item(CMD_INSERT, 32'd1, 32'd2, 32'd3, 16'h1234, 16'h0));
    send_item(make_item(CMD_QUERY, 32'd1, 32'd2, 32'd3, 16'h0, 16'hbeef));
    send_item(make_item(CMD_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff,
                        16'hffff));
    drain_results();
  endtask

  // Field extremes, append, overflow of one cell and per-cell hit list
  task automatic test_field_extremes();
    send_item(make_item(CMD_BUILD, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    send_item(make_item(CMD_INSERT, 32'h80000000, 32'h7fffffff, 32'hffffffff, 16'h0, 16'h0));
    send_item(make_item(CMD_INSERT, 32'h7fffffff, 32'h80000000, 32'h0, 16'hffff, 16'hffff));
    send_item(make_item(CMD_INSERT, 32'h0, 32'h0, 32'h0, 16'h5a5a, 16'h0));
    send_item(make_item(CMD_INSERT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'ha5a5,
                        16'h0));
    for (int i = 0; i < PER_CELL + 1; i++)
      send_item(make_item(CMD_INSERT, 32'h0, 32'h0, 32'h0, 16'(i * 4099), 16'h0));
    send_item(make_item(CMD_QUERY, 32'h0, 32'h0, 32'h0, 16'h0, 16'hffff));
    send_item(make_item(CMD_QUERY, 32'h80000000, 32'h7fffffff, 32'hffffffff, 16'hffff,
                        16'h0));
    send_item(make_item(CMD_QUERY, 32'd5, 32'd6, 32'd7, 16'h0, 16'h1357));
    send_item(make_item(CMD_NONE, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
    drain_results();
  endtask

  // Load limit at zero, one and a few cells
  task automatic test_load_limit();
    logic [10:0] limits [3] = '{11'd0, 11'd1, 11'd3};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      send_item(make_item(CMD_BUILD, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
      for (int i = 0; i < 5; i++)
        send_item(make_item(CMD_INSERT, 32'(i), 32'(-i), 32'(k), 16'(i), 16'h0));
      send_item(make_item(CMD_INSERT, 32'd0, 32'd0, 32'(k), 16'h7777, 16'h0));
      send_item(make_item(CMD_QUERY, 32'd0, 32'd0, 32'(k), 16'h0, 16'(k)));
      drain_results();
    end
  endtask

  // Enough builds to wrap the generation twice and clear every tag
  task automatic test_generation_wrap();
    for (int i = 0; i < 7; i++) begin
      send_item(make_item(CMD_BUILD, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
      if (i % 3 == 1) begin
        send_item(make_item(CMD_INSERT, 32'(i), 32'h0, 32'h0, 16'(i), 16'h0));
        send_item(make_item(CMD_QUERY, 32'(i), 32'h0, 32'h0, 16'h0, 16'(i)));
      end
    end
    send_item(make_item(CMD_QUERY, 32'd4, 32'h0, 32'h0, 16'h0, 16'h0));
    drain_results();
  endtask

  // Random mix over a small cell pool, plus noise and one full pause
  task automatic test_random_mix();
    logic [10:0] limits [4];
    int          pick;
    int          roll;
    in_item_t    it;
    limits = '{CELL_LIMIT_RST, 11'd1024, 11'd4, 11'($urandom_range(1, 1024))};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      // One round runs with no idling on either side
      jitter_on = (k != 2);
      foreach (pool_x[p]) begin
        pool_x[p] = $urandom;
        pool_y[p] = $urandom;
        pool_z[p] = $urandom;
      end
      pool_x[0] = 32'h80000000;
      pool_y[1] = 32'hffffffff;
      pool_z[2] = 32'h7fffffff;
      send_item(make_item(CMD_BUILD, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0));
      for (int n = 0; n < 10; n++) begin
        pick = $urandom_range(POOL_N - 1);
        roll = $urandom_range(99);
        it = make_item(CMD_INSERT, pool_x[pick], pool_y[pick], pool_z[pick],
                       16'($urandom), 16'($urandom));
        if (roll >= 50 && roll < 85) it.command = CMD_QUERY;
        else if (roll >= 85 && roll < 90) it.command = CMD_BUILD;
        else if (roll >= 90 && roll < 94) it.command = CMD_NONE;
        if (roll >= 94) begin
          it.command = (roll & 1) ? CMD_QUERY : CMD_INSERT;
          it.cell_x = $urandom;
          it.cell_y = $urandom;
          it.cell_z = $urandom;
        end
        send_item(it);
        // Hold the sender until the table has answered everything
        if (k == 1 && n == 4) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
          @(negedge clk);
        end
      end
      drain_results();
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    foreach (slot_gen[i]) slot_gen[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_before_build();
    test_field_extremes();
    test_load_limit();
    test_generation_wrap();
    test_random_mix();
    write_limit(CELL_LIMIT_RST);
    repeat (SETTLE) @(negedge clk);
    $display("Ran %0d items and checked %0d results: builds with wrap, limits 0 to 1024,",
             items_sent, results_seen);
    $display("cell overflow, a pause and random pool traffic; %0d mismatches", errors);
    if (errors == 0 && pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: spatial_cell_hash_table.f
sv/scht_pkg.sv
sv/scht_ctrl.sv
sv/scht_dp.sv
sv/spatial_cell_hash_table.sv
verif/testbench.sv
